### sv/srf_pkg.sv
// shared types and constants of the smallest primitive root finder
// no dependencies
`default_nettype none
package srf_pkg;

  localparam int unsigned MOD_WIDTH_DEF   = 31;
  localparam int unsigned MAX_FACTORS_DEF = 10;
  localparam int unsigned PORT_WIDTH      = 31;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_FSQ, S_FCMP, S_FWAIT, S_FRDIV, S_FTAIL,
    S_CAND, S_KRD, S_KCHK, S_EWAIT, S_PSTEP,
    S_MULA, S_MODA, S_WAITA, S_MULB, S_MODB, S_WAITB, S_FIN
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_SQ, CMD_FDIV, CMD_FADD, CMD_NEXTD, CMD_TAIL,
    CMD_KINIT, CMD_EDIV, CMD_ESET, CMD_MULA, CMD_MULB, CMD_MOD,
    CMD_ACC, CMD_BASE, CMD_NEXTK, CMD_NEXTG, CMD_PASS, CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic m_small;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic k_end;
    logic g_end;
    logic e_zero;
    logic e_lsb;
    logic acc_one;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

### sv/srf_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing but its parameter
`default_nettype none
module srf_div #(
  parameter int unsigned W = 31
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [2*W-1:0] dividend_i,
  input  wire logic [W-1:0]   divisor_i,
  output logic                done_o,
  output logic [2*W-1:0]      quot_o,
  output logic [W-1:0]        rem_o
);
  localparam int unsigned CNW = $clog2(2 * W + 1);

  logic           busy_q, busy_d, done_q, done_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [W-1:0]   rem_q, rem_d, dsr_q, dsr_d;
  logic [2*W-1:0] quo_q, quo_d;
  logic [W:0]     trial;
  logic           ge;

  always_comb begin
    trial  = {rem_q, quo_q[2*W-1]};
    ge     = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? W'(trial - {1'b0, dsr_q}) : trial[W-1:0];
      quo_d = {quo_q[2*W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNW'(2 * W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### sv/srf_dp.sv
// datapath: operand registers, factor memory, multiplier and result register
// depends on srf_pkg and srf_div
`default_nettype none
module srf_dp #(
  parameter int unsigned W   = 31,
  parameter int unsigned MAXF = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire srf_pkg::cmd_e          cmd_i,
  input  wire logic [W-1:0]           m_i,
  input  wire logic                   out_ready_i,
  output srf_pkg::status_t            status_o,
  output logic                        out_valid_o,
  output logic [W-1:0]                root_o,
  output logic                        found_o
);
  import srf_pkg::*;

  localparam int unsigned CW = $clog2(MAXF + 1);
  localparam int unsigned IW = (MAXF > 1) ? $clog2(MAXF) : 1;

  logic [W-1:0]   m_q, x_q, d_q, g_q, e_q, acc_q, base_q, fac_rd_q;
  logic [W-1:0]   res_root_q, root_q;
  logic           res_found_q, found_q, added_q, out_valid_q;
  logic [CW-1:0]  cnt_q, k_q;
  logic [2*W-1:0] prod_q;
  logic [W-1:0]   fac_mem [MAXF];

  logic [W-1:0]   mul_a, mul_b, div_dsr, fac_wd;
  logic [2*W-1:0] div_dvd, div_quot;
  logic [W-1:0]   div_rem;
  logic           div_start, div_done, fac_we, room;

  srf_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign room = cnt_q < CW'(MAXF);

  always_comb begin
    mul_a = d_q;
    mul_b = d_q;
    unique case (cmd_i)
      CMD_MULA: begin mul_a = acc_q;  mul_b = base_q; end
      CMD_MULB: begin mul_a = base_q; mul_b = base_q; end
      default:  ;
    endcase
    div_start = 1'b0;
    div_dvd   = prod_q;
    div_dsr   = m_q;
    unique case (cmd_i)
      CMD_FDIV: begin div_start = 1'b1; div_dvd = {{W{1'b0}}, x_q};         div_dsr = d_q; end
      CMD_EDIV: begin div_start = 1'b1; div_dvd = {{W{1'b0}}, m_q - 1'b1}; div_dsr = fac_rd_q; end
      CMD_MOD:  div_start = 1'b1;
      default:  ;
    endcase
    fac_we = 1'b0;
    fac_wd = x_q;
    if (cmd_i == CMD_FADD) begin
      fac_we = room && !added_q;
      fac_wd = d_q;
    end else if (cmd_i == CMD_TAIL) begin
      fac_we = room && (x_q > W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (fac_we) fac_mem[cnt_q[IW-1:0]] <= fac_wd;
    fac_rd_q <= fac_mem[k_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        m_q <= m_i;
        x_q <= m_i - 1'b1;
        d_q <= W'(2);
        cnt_q <= '0;
        added_q <= 1'b0;
        res_root_q <= '0;
        res_found_q <= 1'b0;
      end
      CMD_SQ, CMD_MULA, CMD_MULB: prod_q <= mul_a * mul_b;
      CMD_FADD: begin
        x_q <= div_quot[W-1:0];
        added_q <= 1'b1;
        if (fac_we) cnt_q <= cnt_q + 1'b1;
      end
      CMD_NEXTD: begin
        d_q <= d_q + 1'b1;
        added_q <= 1'b0;
      end
      CMD_TAIL: begin
        g_q <= W'(2);
        if (fac_we) cnt_q <= cnt_q + 1'b1;
      end
      CMD_KINIT: k_q <= '0;
      CMD_ESET: begin
        e_q <= div_quot[W-1:0];
        acc_q <= W'(1);
        base_q <= g_q;
      end
      CMD_ACC: acc_q <= div_rem;
      CMD_BASE: begin
        base_q <= div_rem;
        e_q <= e_q >> 1;
      end
      CMD_NEXTK: k_q <= k_q + 1'b1;
      CMD_NEXTG: g_q <= g_q + 1'b1;
      CMD_PASS: begin
        res_root_q <= g_q;
        res_found_q <= 1'b1;
      end
      CMD_EMIT: begin
        root_q <= res_root_q;
        found_q <= res_found_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    status_o.m_small  = m_q < W'(3);
    status_o.sq_gt    = prod_q > {{W{1'b0}}, x_q};
    status_o.div_done = div_done;
    status_o.rem_zero = div_rem == '0;
    status_o.k_end    = k_q == cnt_q;
    status_o.g_end    = g_q >= m_q;
    status_o.e_zero   = e_q == '0;
    status_o.e_lsb    = e_q[0];
    status_o.acc_one  = acc_q == W'(1);
    status_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;
  assign found_o     = found_q;
endmodule
`default_nettype wire

### sv/srf_ctrl.sv
// controller state machine sequencing factoring and candidate tests
// depends on srf_pkg
`default_nettype none
module srf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire srf_pkg::status_t status_i,
  output logic                  in_ready_o,
  output srf_pkg::cmd_e         cmd_o
);
  import srf_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_START;
      S_START: state_d = status_i.m_small ? S_FIN : S_FSQ;
      S_FSQ:   state_d = S_FCMP;
      S_FCMP:  state_d = status_i.sq_gt ? S_FTAIL : S_FWAIT;
      S_FWAIT: if (status_i.div_done) state_d = status_i.rem_zero ? S_FRDIV : S_FSQ;
      S_FRDIV: state_d = S_FWAIT;
      S_FTAIL: state_d = S_CAND;
      S_CAND:  state_d = status_i.g_end ? S_FIN : S_KRD;
      S_KRD:   state_d = status_i.k_end ? S_FIN : S_KCHK;
      S_KCHK:  state_d = S_EWAIT;
      S_EWAIT: if (status_i.div_done) state_d = S_PSTEP;
      S_PSTEP: begin
        if (status_i.e_zero) state_d = status_i.acc_one ? S_CAND : S_KRD;
        else state_d = status_i.e_lsb ? S_MULA : S_MULB;
      end
      S_MULA:  state_d = S_MODA;
      S_MODA:  state_d = S_WAITA;
      S_WAITA: if (status_i.div_done) state_d = S_MULB;
      S_MULB:  state_d = S_MODB;
      S_MODB:  state_d = S_WAITB;
      S_WAITB: if (status_i.div_done) state_d = S_PSTEP;
      S_FIN:   if (!status_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = CMD_NONE;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) cmd_o = CMD_LOAD;
      S_FSQ:   cmd_o = CMD_SQ;
      S_FCMP:  if (!status_i.sq_gt) cmd_o = CMD_FDIV;
      S_FWAIT: if (status_i.div_done) cmd_o = status_i.rem_zero ? CMD_FADD : CMD_NEXTD;
      S_FRDIV: cmd_o = CMD_FDIV;
      S_FTAIL: cmd_o = CMD_TAIL;
      S_CAND:  if (!status_i.g_end) cmd_o = CMD_KINIT;
      S_KRD:   if (status_i.k_end) cmd_o = CMD_PASS;
      S_KCHK:  cmd_o = CMD_EDIV;
      S_EWAIT: if (status_i.div_done) cmd_o = CMD_ESET;
      S_PSTEP: if (status_i.e_zero) cmd_o = status_i.acc_one ? CMD_NEXTG : CMD_NEXTK;
      S_MULA:  cmd_o = CMD_MULA;
      S_MODA:  cmd_o = CMD_MOD;
      S_WAITA: if (status_i.div_done) cmd_o = CMD_ACC;
      S_MULB:  cmd_o = CMD_MULB;
      S_MODB:  cmd_o = CMD_MOD;
      S_WAITB: if (status_i.div_done) cmd_o = CMD_BASE;
      S_FIN:   if (!status_i.out_busy) cmd_o = CMD_EMIT;
      default: cmd_o = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_ready_o = state_q == S_IDLE;
endmodule
`default_nettype wire

### sv/smallest_primitive_root_finder.sv
// top level of the smallest primitive root finder
// depends on srf_pkg, srf_ctrl, srf_dp (and srf_div below it)
//
// channel  dir  handshake            payload
// input    in   in_valid_i/ready_o   modulus_i[30:0]
// output   out  out_valid_o/ready_i  root_o[30:0], found_o
//
// one item at a time; each trial division and each modular reduction runs on
// the shared divider
// a finished result waits in the output register while the next item starts
// reset clears the controller and output valid; no clearing pass is needed
`default_nettype none
module smallest_primitive_root_finder #(
  parameter int unsigned MOD_WIDTH   = srf_pkg::MOD_WIDTH_DEF,
  parameter int unsigned MAX_FACTORS = srf_pkg::MAX_FACTORS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [srf_pkg::PORT_WIDTH-1:0] modulus_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [srf_pkg::PORT_WIDTH-1:0]      root_o,
  output logic                                found_o
);
  import srf_pkg::*;

  status_t              status;
  cmd_e                 cmd;
  logic [MOD_WIDTH-1:0] root;

  srf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  srf_dp #(.W(MOD_WIDTH), .MAXF(MAX_FACTORS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .m_i         (modulus_i[MOD_WIDTH-1:0]),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .root_o      (root),
    .found_o     (found_o)
  );

  assign root_o = PORT_WIDTH'(root);
endmodule
`default_nettype wire

### sv/srf_checker.sv
// port-level checks of the smallest primitive root finder, bound to the top
// depends on smallest_primitive_root_finder
`default_nettype none
module srf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [30:0] root_o,
  input wire logic        found_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_o) && $stable(found_o))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> root_o == 31'd0)
    else $error("root nonzero without found");

  a_found_ge2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> root_o >= 31'd2)
    else $error("found root below two");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an item");
endmodule

bind smallest_primitive_root_finder srf_checker u_srf_checker (.*);
`default_nettype wire
